FILE: hw/rtl/assert_macros.svh
// assertion helpers, each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSPH_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define MSPH_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/msph_pkg.sv
`timescale 1ns / 1ps
package msph_pkg;

  localparam int CHANNELS = 16;
  localparam int NOTES    = 128;
  localparam int CHAN_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CTRL     = 4'hB;

  localparam logic [6:0] CC_SUSTAIN   = 7'd64;
  localparam logic [6:0] CC_SOSTENUTO = 7'd66;

  localparam logic [1:0] KIND_FWD   = 2'd0;
  localparam logic [1:0] KIND_SYNTH = 2'd1;
  localparam logic [1:0] KIND_MASK  = 2'd2;

  // notes 64 and up that exist
  localparam logic [63:0] GRP1_MASK = (NOTES >= 128) ? {64{1'b1}} :
                                      ((64'd1 << (NOTES - 64)) - 64'd1);
  localparam logic [127:0] NOTE_MASK = {GRP1_MASK, {64{1'b1}}};

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [31:0] time_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_status;
    logic [6:0]  out_data_one;
    logic [6:0]  out_data_two;
    logic [31:0] out_time_tag;
    logic        note_group;
    logic [63:0] held_mask;
    logic        last;
  } out_item_t;

  // one memory word per channel, bit n is note n
  typedef struct packed {
    logic [127:0] key_down;
    logic [127:0] eligible;
    logic [127:0] held;
  } chan_state_t;

endpackage

FILE: hw/rtl/msph_ram.sv
`timescale 1ns / 1ps
module msph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/msph_oq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msph_oq
  import msph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] push_n,
  input  out_item_t push_a,
  input  out_item_t push_b,
  output logic [1:0] free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  q_r   [2];
  out_item_t  q_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_b;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;
  assign cnt_b     = cnt_r - {1'b0, pop};
  assign free      = 2'd2 - cnt_b;
  assign cnt_nxt   = cnt_b + push_n;

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push_n != 2'd0) begin
      if (cnt_b == 2'd0) begin
        q_nxt[0] = push_a;
        if (push_n == 2'd2) begin
          q_nxt[1] = push_b;
        end
      end else begin
        q_nxt[1] = push_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  `MSPH_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2)
  `MSPH_ASSERT_IMP(a_push_room, push_n != 2'd0, push_n <= free)
  `MSPH_ASSERT_NXT(a_pop_count, pop && (push_n == 2'd0), cnt_r == $past(cnt_r) - 2'd1)

endmodule

FILE: hw/rtl/midi_sustain_pedal_holder.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// sustain / sostenuto pedal holder for a midi message stream
// input channel: in_valid / in_ready with in_data (status, two data bytes, time tag)
// result channel: out_valid / out_ready with out_data; last marks the final
// result of an input; held note-offs, pedal presses and releases with nothing
// held produce no result, a release sends one mask per group with held notes
// cfg_wr_en / cfg_wr_data write sostenuto_mode (0: controller 64, 1: controller 66)
// per-channel key-down, eligible and held bits live in one 16 x 384 memory,
// read when an input transfer happens and written back as the processing stage retires it;
// a back-to-back message on the same channel takes the forwarded word
// each input is registered in the processing stage, its results in the result queue
// throughput: one input per cycle while each gives at most one result and out_ready
// stays high; an input with two results (synthesized note-off, or two held
// masks) needs two output transfers, the 2-entry result queue sets the pace
// reset: pedal bits, per-channel valid bits and the queue clear at once, so
// all state reads as zero right after reset with no clearing pass
// receiver stall: the queue fills, then the processing stage waits and
// in_ready drops until room opens up
module midi_sustain_pedal_holder
  import msph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic                sost_r;
  logic [CHANNELS-1:0] pedal_r;
  logic [CHANNELS-1:0] pedal_nxt;
  logic [CHANNELS-1:0] chan_vld_r;

  logic                s1_v_r;
  in_item_t            s1_item_r;
  logic                fwd_hit_r;
  chan_state_t         fwd_state_r;

  logic                accept;
  logic                s1_done;
  logic [CHAN_AW-1:0]  in_idx;
  logic [CHAN_AW-1:0]  s1_idx;
  chan_state_t         ram_rdata;
  chan_state_t         cur;
  chan_state_t         nxt;
  logic                wr_req;
  logic                wr_en;

  logic [3:0]   msg_type;
  logic [3:0]   ch;
  logic         tracked;
  logic         is_pedal;
  logic         is_note;
  logic         note_on;
  logic         pedal_now;
  logic [127:0] note_bit;
  logic [63:0]  held_lo;
  logic [63:0]  held_hi;

  logic [1:0]   res_n;
  logic [1:0]   free;
  out_item_t    res_a;
  out_item_t    res_b;
  out_item_t    fwd_res;
  out_item_t    mask_lo;
  out_item_t    mask_hi;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_v_r || s1_done;
  assign s1_done  = s1_v_r && (res_n <= free);
  assign wr_en    = s1_done && wr_req;
  assign in_idx   = in_data.status_byte[CHAN_AW-1:0];
  assign s1_idx   = s1_item_r.status_byte[CHAN_AW-1:0];

  msph_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (nxt),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // a row never written reads as zero
  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_state_r;
    end else if (chan_vld_r[s1_idx]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
  end

  assign msg_type  = s1_item_r.status_byte[7:4];
  assign ch        = s1_item_r.status_byte[3:0];
  assign tracked   = int'(ch) < CHANNELS;
  assign is_pedal  = tracked && (msg_type == MSG_CTRL) &&
                     (s1_item_r.data_one == (sost_r ? CC_SOSTENUTO : CC_SUSTAIN));
  assign is_note   = tracked && (int'(s1_item_r.data_one) < NOTES) &&
                     ((msg_type == MSG_NOTE_ON) || (msg_type == MSG_NOTE_OFF));
  assign note_on   = (msg_type == MSG_NOTE_ON) && (s1_item_r.data_two != 7'd0);
  assign pedal_now = pedal_r[s1_idx];
  assign note_bit  = 128'd1 << s1_item_r.data_one;
  assign held_lo   = cur.held[63:0];
  assign held_hi   = cur.held[127:64];

  always_comb begin
    fwd_res              = '0;
    fwd_res.out_kind     = KIND_FWD;
    fwd_res.out_status   = s1_item_r.status_byte;
    fwd_res.out_data_one = s1_item_r.data_one;
    fwd_res.out_data_two = s1_item_r.data_two;
    fwd_res.out_time_tag = s1_item_r.time_tag;
    fwd_res.last         = 1'b1;

    mask_lo              = '0;
    mask_lo.out_kind     = KIND_MASK;
    mask_lo.out_status   = {MSG_NOTE_OFF, ch};
    mask_lo.out_time_tag = s1_item_r.time_tag;
    mask_lo.note_group   = 1'b0;
    mask_lo.held_mask    = held_lo;
    mask_lo.last         = (held_hi == 64'd0);

    mask_hi              = mask_lo;
    mask_hi.note_group   = 1'b1;
    mask_hi.held_mask    = held_hi;
    mask_hi.last         = 1'b1;
  end

  always_comb begin
    nxt       = cur;
    pedal_nxt = pedal_r;
    wr_req    = 1'b0;
    res_n     = 2'd1;
    res_a     = fwd_res;
    res_b     = fwd_res;
    if (is_pedal) begin
      res_n = 2'd0;
      if (s1_item_r.data_two[6] && !pedal_now) begin
        pedal_nxt[s1_idx] = 1'b1;
        nxt.eligible      = sost_r ? (cur.key_down & NOTE_MASK) : NOTE_MASK;
        wr_req            = 1'b1;
      end else if (!s1_item_r.data_two[6] && pedal_now) begin
        pedal_nxt[s1_idx] = 1'b0;
        nxt.eligible      = '0;
        nxt.held          = '0;
        wr_req            = 1'b1;
        if (held_lo != 64'd0) begin
          res_a = mask_lo;
          res_b = mask_hi;
          res_n = (held_hi != 64'd0) ? 2'd2 : 2'd1;
        end else if (held_hi != 64'd0) begin
          res_a = mask_hi;
          res_n = 2'd1;
        end
      end
    end else if (is_note) begin
      wr_req = 1'b1;
      if (note_on) begin
        nxt.key_down = cur.key_down | note_bit;
        if ((cur.held & note_bit) != '0) begin
          // held note struck again: release it first
          nxt.held           = cur.held & ~note_bit;
          res_a              = '0;
          res_a.out_kind     = KIND_SYNTH;
          res_a.out_status   = {MSG_NOTE_OFF, ch};
          res_a.out_data_one = s1_item_r.data_one;
          res_a.out_time_tag = s1_item_r.time_tag;
          res_b              = fwd_res;
          res_n              = 2'd2;
        end
      end else begin
        nxt.key_down = cur.key_down & ~note_bit;
        if (pedal_now && ((cur.eligible & note_bit) != '0)) begin
          nxt.held = cur.held | note_bit;
          res_n    = 2'd0;
        end
      end
    end
  end

  msph_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (s1_done ? res_n : 2'd0),
    .push_a    (res_a),
    .push_b    (res_b),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sost_r     <= 1'b0;
      pedal_r    <= '0;
      chan_vld_r <= '0;
      s1_v_r     <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sost_r <= cfg_wr_data;
      end
      if (s1_done) begin
        pedal_r <= pedal_nxt;
      end
      if (wr_en) begin
        chan_vld_r[s1_idx] <= 1'b1;
      end
      if (accept) begin
        s1_v_r    <= 1'b1;
        // write-back to the same row lands as this read is issued
        fwd_hit_r <= wr_en && (s1_idx == in_idx);
      end else if (s1_done) begin
        s1_v_r <= 1'b0;
      end
    end
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (wr_en) begin
      fwd_state_r <= nxt;
    end
  end

  `MSPH_ASSERT_IMP(a_mask_nonzero, out_valid && (out_data.out_kind == KIND_MASK),
    out_data.held_mask != 64'd0)
  `MSPH_ASSERT_IMP(a_held_eligible, wr_en, (nxt.held & ~nxt.eligible) == '0)
  `MSPH_ASSERT_IMP(a_stall_blocks, s1_v_r && !s1_done, !in_ready)

endmodule

FILE: tb/tb_midi_sustain_pedal_holder.sv
`timescale 1ns / 1ps
module tb_midi_sustain_pedal_holder;
  import msph_pkg::*;

  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_MSGS    = 125;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  // tracks pedal, key-down, eligible and held bits per channel and
  // predicts the message stream that comes out of the block
  class sustain_tracker;
    bit             sostenuto;
    bit             pedal_dn[CHANNELS];
    bit [NOTES-1:0] keys_dn[CHANNELS];
    bit [NOTES-1:0] eligible[CHANNELS];
    bit [NOTES-1:0] held[CHANNELS];
    out_item_t      expected_msgs[$];
    int             errors;
    int             accepted;
    int             delivered;
    int             synth_offs;
    int             mask_msgs;

    function out_item_t make_msg(logic [1:0] kind, logic [7:0] st, logic [6:0] d1,
                                 logic [6:0] d2, logic [31:0] tag, logic grp,
                                 logic [63:0] mask, logic last);
      out_item_t r;
      r.out_kind     = kind;
      r.out_status   = st;
      r.out_data_one = d1;
      r.out_data_two = d2;
      r.out_time_tag = tag;
      r.note_group   = grp;
      r.held_mask    = mask;
      r.last         = last;
      return r;
    endfunction

    function void take_message(in_item_t m);
      logic [3:0]  kind;
      logic [3:0]  ch;
      logic [6:0]  cc;
      logic [7:0]  off_st;
      logic [63:0] lo_mask;
      logic [63:0] hi_mask;
      accepted++;
      kind   = m.status_byte[7:4];
      ch     = m.status_byte[3:0];
      cc     = sostenuto ? CC_SOSTENUTO : CC_SUSTAIN;
      off_st = {MSG_NOTE_OFF, ch};
      if (kind == MSG_CTRL && m.data_one == cc) begin
        // pedal messages are swallowed
        if (m.data_two >= 7'd64 && !pedal_dn[ch]) begin
          pedal_dn[ch] = 1'b1;
          eligible[ch] = sostenuto ? (keys_dn[ch] & NOTE_MASK) : NOTE_MASK;
        end else if (m.data_two < 7'd64 && pedal_dn[ch]) begin
          pedal_dn[ch] = 1'b0;
          lo_mask = held[ch][63:0];
          hi_mask = held[ch][127:64];
          if (lo_mask != '0)
            expected_msgs.push_back(make_msg(KIND_MASK, off_st, '0, '0, m.time_tag,
                                             1'b0, lo_mask, hi_mask == '0));
          if (hi_mask != '0)
            expected_msgs.push_back(make_msg(KIND_MASK, off_st, '0, '0, m.time_tag,
                                             1'b1, hi_mask, 1'b1));
          held[ch]     = '0;
          eligible[ch] = '0;
        end
        return;
      end
      if (kind == MSG_NOTE_ON || kind == MSG_NOTE_OFF) begin
        if (kind == MSG_NOTE_ON && m.data_two != '0) begin
          keys_dn[ch][m.data_one] = 1'b1;
          if (held[ch][m.data_one]) begin
            held[ch][m.data_one] = 1'b0;
            expected_msgs.push_back(make_msg(KIND_SYNTH, off_st, m.data_one, '0,
                                             m.time_tag, 1'b0, '0, 1'b0));
          end
        end else begin
          keys_dn[ch][m.data_one] = 1'b0;
          if (pedal_dn[ch] && eligible[ch][m.data_one]) begin
            held[ch][m.data_one] = 1'b1;
            return;
          end
        end
      end
      expected_msgs.push_back(make_msg(KIND_FWD, m.status_byte, m.data_one, m.data_two,
                                       m.time_tag, 1'b0, '0, 1'b1));
    endfunction

    task report(string line);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, line);
    endtask

    task field_check(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_msg(out_item_t got);
      out_item_t want;
      delivered++;
      if (expected_msgs.size() == 0) begin
        report($sformatf("result with nothing pending, status %0h kind %0d",
                         got.out_status, got.out_kind));
        return;
      end
      want = expected_msgs.pop_front();
      if (want.out_kind == KIND_SYNTH) synth_offs++;
      if (want.out_kind == KIND_MASK) mask_msgs++;
      field_check("out_kind", 64'(got.out_kind), 64'(want.out_kind));
      field_check("out_status", 64'(got.out_status), 64'(want.out_status));
      field_check("out_data_one", 64'(got.out_data_one), 64'(want.out_data_one));
      field_check("out_data_two", 64'(got.out_data_two), 64'(want.out_data_two));
      field_check("out_time_tag", 64'(got.out_time_tag), 64'(want.out_time_tag));
      field_check("note_group", 64'(got.note_group), 64'(want.note_group));
      field_check("held_mask", got.held_mask, want.held_mask);
      field_check("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  sustain_tracker sb;
  bit             cur_mode;
  bit             no_idle;
  bit             hold_req;
  int             cycle_count;
  logic [3:0]     chan_pick[2];
  logic [6:0]     note_pool[8];

  midi_sustain_pedal_holder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic send_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2, logic [31:0] tag);
    int gap;
    gap = hold_req ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{status_byte: st, data_one: d1, data_two: d2, time_tag: tag};
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every pending result, then let pedal messages still in flight retire
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.sostenuto = v;
    cur_mode     = v;
  endtask

  // small channel and note pools so that pedal, hold and re-strike collide often
  function automatic in_item_t random_message();
    in_item_t m;
    logic [3:0] ch;
    int pick;
    m.time_tag  = $urandom();
    ch          = ($urandom_range(0, 3) != 0) ? chan_pick[$urandom_range(0, 1)]
                                              : 4'($urandom_range(0, 15));
    m.data_one  = ($urandom_range(0, 3) != 0) ? note_pool[$urandom_range(0, 7)]
                                              : 7'($urandom_range(0, 127));
    m.data_two  = 7'($urandom_range(1, 127));
    pick        = $urandom_range(0, 99);
    if (pick < 35) begin
      m.status_byte = {MSG_NOTE_ON, ch};
    end else if (pick < 50) begin
      m.status_byte = {MSG_NOTE_OFF, ch};
      m.data_two    = 7'($urandom_range(0, 127));
    end else if (pick < 60) begin
      m.status_byte = {MSG_NOTE_ON, ch};
      m.data_two    = '0;
    end else if (pick < 80) begin
      m.status_byte = {MSG_CTRL, ch};
      m.data_one    = cur_mode ? CC_SOSTENUTO : CC_SUSTAIN;
      m.data_two    = 7'($urandom_range(0, 127));
    end else if (pick < 88) begin
      m.status_byte = {MSG_CTRL, ch};
      m.data_one    = ($urandom_range(0, 1) != 0) ? (cur_mode ? CC_SUSTAIN : CC_SOSTENUTO)
                                                  : 7'($urandom_range(0, 127));
      m.data_two    = 7'($urandom_range(0, 127));
    end else begin
      m.status_byte = 8'($urandom_range(0, 255));
      m.data_one    = 7'($urandom_range(0, 127));
      m.data_two    = 7'($urandom_range(0, 127));
    end
    return m;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_message(in_data);
      if (out_valid && out_ready) sb.check_msg(out_data);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      n = idle_len();
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (n == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run timed out after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_item_t m;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sustain mode
    write_mode(1'b0);
    send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd127, 32'h0000_0000);
    send_msg({MSG_NOTE_ON, 4'd15}, 7'd127, 7'd1, 32'hFFFF_FFFF);
    send_msg({MSG_CTRL, 4'd0}, CC_SUSTAIN, 7'd64, $urandom());   // exactly at threshold
    send_msg({MSG_CTRL, 4'd0}, CC_SUSTAIN, 7'd127, $urandom());  // already down
    send_msg({MSG_NOTE_OFF, 4'd0}, 7'd0, 7'd0, $urandom());      // held back
    send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd0, $urandom());       // off again while held
    send_msg({MSG_NOTE_ON, 4'd0}, 7'd0, 7'd100, $urandom());     // re-strike of held note
    send_msg({MSG_NOTE_OFF, 4'd0}, 7'd0, 7'd64, $urandom());
    send_msg({MSG_NOTE_OFF, 4'd0}, 7'd127, 7'd127, $urandom());  // never pressed, still held
    send_msg({MSG_CTRL, 4'd0}, CC_SUSTAIN, 7'd63, $urandom());   // release, both groups
    send_msg({MSG_CTRL, 4'd0}, CC_SUSTAIN, 7'd0, $urandom());    // already up
    send_msg({MSG_CTRL, 4'd15}, CC_SUSTAIN, 7'd100, $urandom());
    send_msg({MSG_CTRL, 4'd15}, CC_SUSTAIN, 7'd10, $urandom());  // release with nothing held
    send_msg({MSG_CTRL, 4'd0}, CC_SOSTENUTO, 7'd127, $urandom()); // not the pedal here
    send_msg(8'h00, 7'd0, 7'd0, $urandom());
    send_msg(8'h7F, 7'd127, 7'd127, $urandom());
    send_msg(8'hA5, 7'd42, 7'd85, $urandom());
    send_msg(8'hF0, 7'd1, 7'd2, $urandom());
    send_msg(8'hFF, 7'd127, 7'd127, $urandom());
    send_msg({MSG_NOTE_OFF, 4'd15}, 7'd127, 7'd127, $urandom()); // pedal up, forwarded
    settle();

    // sostenuto mode
    write_mode(1'b1);
    send_msg({MSG_NOTE_ON, 4'd3}, 7'd64, 7'd5, $urandom());
    send_msg({MSG_NOTE_ON, 4'd3}, 7'd1, 7'd90, $urandom());
    send_msg({MSG_CTRL, 4'd3}, CC_SOSTENUTO, 7'd100, $urandom()); // only keys down
    send_msg({MSG_CTRL, 4'd3}, CC_SUSTAIN, 7'd127, $urandom());   // forwarded in this mode
    send_msg({MSG_NOTE_ON, 4'd3}, 7'd64, 7'd0, $urandom());       // held
    send_msg({MSG_NOTE_OFF, 4'd3}, 7'd2, 7'd30, $urandom());      // not eligible
    send_msg({MSG_NOTE_OFF, 4'd3}, 7'd1, 7'd30, $urandom());      // held
    send_msg({MSG_NOTE_ON, 4'd3}, 7'd1, 7'd77, $urandom());
    send_msg({MSG_NOTE_OFF, 4'd3}, 7'd1, 7'd0, $urandom());
    send_msg({MSG_CTRL, 4'd3}, CC_SOSTENUTO, 7'd0, $urandom());
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_mode(ph[0]);
      chan_pick[0] = 4'($urandom_range(0, 15));
      chan_pick[1] = 4'($urandom_range(0, 15));
      for (int i = 0; i < 8; i++)
        note_pool[i] = 7'($urandom_range(0, 63)) + ((i < 4) ? 7'd0 : 7'd64);
      no_idle  = (ph == 2);
      hold_req = (ph == 1);  // result side stalls long while messages keep coming
      for (int i = 0; i < PHASE_MSGS; i++) begin
        m = random_message();
        send_msg(m.status_byte, m.data_one, m.data_two, m.time_tag);
      end
      settle();
    end

    $display("covered %0d input transfers and %0d result transfers in sustain and sostenuto",
             sb.accepted, sb.delivered);
    $display("including %0d re-strike note-offs and %0d held masks, %0d mismatches",
             sb.synth_offs, sb.mask_msgs, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: midi_sustain_pedal_holder.f
+incdir+hw/rtl
hw/rtl/msph_pkg.sv
hw/rtl/msph_ram.sv
hw/rtl/msph_oq.sv
hw/rtl/midi_sustain_pedal_holder.sv
tb/tb_midi_sustain_pedal_holder.sv
